// File: design/gr16_pkg.sv
// Package for the sixteen-lane fp32 row accumulator.
// Holds shared constants, the sequencer control struct and fp32 helper functions.
// Depends on nothing; the lane, sequencer and top-level files refer to it by scoped names.
package gr16_pkg;

  localparam int LANES = 16;
  localparam int PAIRS = 8;

  // Weight encodings
  localparam logic [1:0] FMT_F32  = 2'd0;
  localparam logic [1:0] FMT_F16  = 2'd1;
  localparam logic [1:0] FMT_BF16 = 2'd2;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // Per-phase strobes from the sequencer to every lane
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic add_en;
    logic fin_en;
    logic clear;
  } seq_ctl_t;

  // Widen an fp16 pattern exactly to fp32
  function automatic logic [31:0] widen_f16(logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [31:0] res;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    if (e == 5'd31) begin
      res = {s, 8'hFF, m, 13'b0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) res = {s, 31'b0};
      else res = {s, 8'(8'd103 + {4'b0, p}), 10'(m << (4'd10 - p)), 13'b0};
    end else begin
      res = {s, 8'({3'b0, e} + 8'd112), m, 13'b0};
    end
    return res;
  endfunction

  // Decode one 32-bit weight slot to fp32
  function automatic logic [31:0] widen(logic [1:0] fmt, logic [31:0] slot);
    logic [31:0] res;
    case (fmt)
      FMT_F16:  res = widen_f16(slot[15:0]);
      FMT_BF16: res = {slot[15:0], 16'b0};
      default:  res = slot;
    endcase
    return res;
  endfunction

  // Round sig * 2^(e - 189) to fp32, nearest even; sig is non-zero
  function automatic logic [31:0] round_pack(logic s, logic signed [11:0] e_in,
                                             logic [63:0] sig_in);
    logic [63:0]        sig;
    logic [63:0]        mask;
    logic signed [11:0] e;
    logic signed [11:0] d;
    logic [5:0]         lz;
    logic               found;
    logic [38:0]        rem;
    logic [24:0]        mant;
    logic [31:0]        base;
    logic [31:0]        bits;
    logic [31:0]        res;
    sig = sig_in;
    e = e_in;
    if (sig[63]) begin
      sig = {1'b0, sig[63:1]} | {63'b0, sig[0]};
      e = e + 12'sd1;
    end
    lz = 6'd0;
    found = 1'b0;
    for (int i = 62; i >= 0; i--) begin
      if (!found) begin
        if (sig[i]) found = 1'b1;
        else lz = lz + 6'd1;
      end
    end
    sig = sig << lz;
    e = e - $signed({6'b0, lz});
    base = 32'd0;
    if (e < 12'sd1) begin
      if (e < -12'sd62) begin
        sig = {63'b0, |sig};
      end else begin
        d = 12'sd1 - e;
        mask = (64'd1 << d[6:0]) - 64'd1;
        sig = (sig >> d[6:0]) | {63'b0, |(sig & mask)};
      end
    end else begin
      base = {1'b0, 8'(e[7:0] - 8'd1), 23'b0};
    end
    mant = {1'b0, sig[62:39]};
    rem = sig[38:0];
    if (rem > 39'h40_0000_0000 || (rem == 39'h40_0000_0000 && mant[0])) mant = mant + 25'd1;
    bits = base + {7'b0, mant};
    if (e >= 12'sd255 || bits >= 32'h7F80_0000) res = {s, 31'h7F80_0000};
    else res = {s, bits[30:0]};
    return res;
  endfunction

endpackage

// File: design/gr16_lane.sv
// One accumulation lane: fp32 multiply, product rounding, aligned add, sum rounding.
// Depends on gr16_pkg for the control struct and the fp32 helpers.
module gr16_lane (
  input  logic                clk,
  input  logic                rst,
  input  gr16_pkg::seq_ctl_t  ctl,
  input  logic [1:0]          fmt,
  input  logic [31:0]         act,
  input  logic [31:0]         slot,
  output logic [31:0]         sum
);

  logic [31:0]        w;
  logic               ms, m_s, m_specv, m_specv_next;
  logic [31:0]        m_spec, m_spec_next;
  logic signed [11:0] m_e;
  logic [47:0]        m_prod;
  logic [7:0]         mea, meb;
  logic [23:0]        mma, mmb;
  logic [31:0]        prod;
  logic [31:0]        acc;
  logic               a_s, a_specv, a_specv_next, a_s_next;
  logic [31:0]        a_spec, a_spec_next;
  logic [7:0]         a_e, a_e_next;
  logic [63:0]        a_r, a_r_next;

  // Multiply: classify operands, form the raw 48-bit product
  always_comb begin
    w = gr16_pkg::widen(fmt, slot);
    ms = act[31] ^ w[31];
    mea = act[30:23];
    meb = w[30:23];
    mma = {1'b0, act[22:0]};
    mmb = {1'b0, w[22:0]};
    m_specv_next = 1'b1;
    m_spec_next = {ms, 31'b0};
    if ((mea == 8'hFF && mma != 24'd0) || (meb == 8'hFF && mmb != 24'd0)) begin
      m_spec_next = gr16_pkg::QNAN;
    end else if (mea == 8'hFF || meb == 8'hFF) begin
      if (act[30:0] == 31'd0 || w[30:0] == 31'd0) m_spec_next = gr16_pkg::QNAN;
      else m_spec_next = {ms, 31'h7F80_0000};
    end else if (act[30:0] == 31'd0 || w[30:0] == 31'd0) begin
      m_spec_next = {ms, 31'b0};
    end else begin
      m_specv_next = 1'b0;
    end
    if (mea != 8'd0) mma[23] = 1'b1; else mea = 8'd1;
    if (meb != 8'd0) mmb[23] = 1'b1; else meb = 8'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      m_specv <= m_specv_next;
      m_spec <= m_spec_next;
      m_s <= ms;
      m_e <= $signed({4'b0, mea}) + $signed({4'b0, meb}) - 12'sd111;
      m_prod <= mma * mmb;
    end
  end

  // Round the product to fp32
  always_ff @(posedge clk) begin
    if (ctl.rnd_en) begin
      prod <= m_specv ? m_spec : gr16_pkg::round_pack(m_s, m_e, {16'b0, m_prod});
    end
  end

  // Add: handle specials, order by magnitude, align and add or subtract
  always_comb begin
    logic        sa, sb, tsw;
    logic [7:0]  ea, eb, dx;
    logic [23:0] ma, mb;
    logic [63:0] xa, xb, mask;
    mask = 64'd0;
    sa = acc[31];
    sb = prod[31];
    ea = acc[30:23];
    eb = prod[30:23];
    ma = {1'b0, acc[22:0]};
    mb = {1'b0, prod[22:0]};
    a_specv_next = 1'b1;
    a_spec_next = 32'd0;
    if ((ea == 8'hFF && ma != 24'd0) || (eb == 8'hFF && mb != 24'd0)) begin
      a_spec_next = gr16_pkg::QNAN;
    end else if (ea == 8'hFF && eb == 8'hFF) begin
      a_spec_next = (sa != sb) ? gr16_pkg::QNAN : acc;
    end else if (ea == 8'hFF) begin
      a_spec_next = acc;
    end else if (eb == 8'hFF) begin
      a_spec_next = prod;
    end else if (acc[30:0] == 31'd0 && prod[30:0] == 31'd0) begin
      a_spec_next = {sa & sb, 31'b0};
    end else if (acc[30:0] == 31'd0) begin
      a_spec_next = prod;
    end else if (prod[30:0] == 31'd0) begin
      a_spec_next = acc;
    end else begin
      a_specv_next = 1'b0;
    end
    if (ea != 8'd0) ma[23] = 1'b1; else ea = 8'd1;
    if (eb != 8'd0) mb[23] = 1'b1; else eb = 8'd1;
    tsw = (eb > ea) || (eb == ea && mb > ma);
    if (tsw) begin
      {ea, eb} = {eb, ea};
      {ma, mb} = {mb, ma};
      {sa, sb} = {sb, sa};
    end
    dx = ea - eb;
    xa = {1'b0, ma, 39'b0};
    xb = {1'b0, mb, 39'b0};
    if (dx >= 8'd64) begin
      xb = {63'b0, |xb};
    end else if (dx != 8'd0) begin
      mask = (64'd1 << dx[5:0]) - 64'd1;
      xb = (xb >> dx[5:0]) | {63'b0, |(xb & mask)};
    end
    if (sa == sb) begin
      a_r_next = xa + xb;
    end else begin
      a_r_next = xa - xb;
      if (xa == xb && !a_specv_next) begin
        a_specv_next = 1'b1;
        a_spec_next = 32'd0;
      end
    end
    a_s_next = sa;
    a_e_next = ea;
  end

  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      a_specv <= a_specv_next;
      a_spec <= a_spec_next;
      a_s <= a_s_next;
      a_e <= a_e_next;
      a_r <= a_r_next;
    end
  end

  // Round the sum; write back, or drop to +0 at the end of a run
  assign sum = a_specv ? a_spec : gr16_pkg::round_pack(a_s, $signed({4'b0, a_e}), a_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
    end else if (ctl.fin_en) begin
      acc <= ctl.clear ? 32'd0 : sum;
    end
  end

endmodule

// File: design/gr16_seq.sv
// Sequencer: steps each transaction through multiply, round, add and finish phases.
// Depends on gr16_pkg for the control struct; drives the input stall and output valid.
module gr16_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_step,
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output logic               load,
  output gr16_pkg::seq_ctl_t ctl
);

  logic       busy;
  logic [1:0] phase;
  logic       last;
  logic       blocked;

  // Finish waits only while a result is still held and this item makes another
  assign blocked = last && out_valid && out_stall;

  always_comb begin
    ctl.mul_en = busy && phase == 2'd0;
    ctl.rnd_en = busy && phase == 2'd1;
    ctl.add_en = busy && phase == 2'd2;
    ctl.fin_en = busy && phase == 2'd3 && !blocked;
    ctl.clear  = ctl.fin_en && last;
  end

  assign in_stall = busy && !ctl.fin_en;
  assign load = in_valid && !in_stall;

  // Advance the phase counter, hold at finish while blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 2'd0;
      last <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      phase <= 2'd0;
      last <= last_step;
    end else if (ctl.fin_en) begin
      busy <= 1'b0;
    end else if (busy && phase != 2'd3) begin
      phase <= phase + 2'd1;
    end
  end

  // Result register flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.clear) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/gemm_row_dot16_accumulator.sv
// Top level of the sixteen-lane fp32 row accumulator.
// Depends on gr16_pkg, gr16_lane and gr16_seq.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | activation, weights_pair_0..7, last_step
//  out     | output    | out_valid / out_stall | sums_pair_0..7
//  cfg     | input     | cfg_we                | cfg_wdata (weight format)
//
// Each transaction passes through each lane's multiply, round, add and sum-round phases,
// and the next one is taken in the sum-round phase, with the accumulator write-back.
// A result and out_valid are registered at the finish phase of the last step.
// Reset clears the accumulators to +0, the format to fp32, the busy flag and the out valid flag.
// A held result does not stop input; only a last step meeting a held result waits.
module gemm_row_dot16_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] activation,
  input  logic [63:0] weights_pair_0,
  input  logic [63:0] weights_pair_1,
  input  logic [63:0] weights_pair_2,
  input  logic [63:0] weights_pair_3,
  input  logic [63:0] weights_pair_4,
  input  logic [63:0] weights_pair_5,
  input  logic [63:0] weights_pair_6,
  input  logic [63:0] weights_pair_7,
  input  logic        last_step,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] sums_pair_0,
  output logic [63:0] sums_pair_1,
  output logic [63:0] sums_pair_2,
  output logic [63:0] sums_pair_3,
  output logic [63:0] sums_pair_4,
  output logic [63:0] sums_pair_5,
  output logic [63:0] sums_pair_6,
  output logic [63:0] sums_pair_7
);

  logic [1:0]         weight_format;
  logic               load;
  gr16_pkg::seq_ctl_t ctl;
  logic [31:0]        act;
  logic [63:0]        wts [gr16_pkg::PAIRS];
  logic [63:0]        wts_in [gr16_pkg::PAIRS];
  logic [31:0]        lane_sum [2 * gr16_pkg::PAIRS];
  logic [63:0]        sums [gr16_pkg::PAIRS];

  // Format register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_format <= gr16_pkg::FMT_F32;
    end else if (cfg_we) begin
      weight_format <= cfg_wdata;
    end
  end

  assign wts_in[0] = weights_pair_0;
  assign wts_in[1] = weights_pair_1;
  assign wts_in[2] = weights_pair_2;
  assign wts_in[3] = weights_pair_3;
  assign wts_in[4] = weights_pair_4;
  assign wts_in[5] = weights_pair_5;
  assign wts_in[6] = weights_pair_6;
  assign wts_in[7] = weights_pair_7;

  // Hold the accepted transaction for the lanes
  always_ff @(posedge clk) begin
    if (load) begin
      act <= activation;
      wts <= wts_in;
    end
  end

  gr16_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_step (last_step),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .load      (load),
    .ctl       (ctl)
  );

  for (genvar l = 0; l < 2 * gr16_pkg::PAIRS; l++) begin : g_lane
    if (l < gr16_pkg::LANES) begin : g_on
      gr16_lane u_lane (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .fmt  (weight_format),
        .act  (act),
        .slot (wts[l / 2][(l % 2) * 32 +: 32]),
        .sum  (lane_sum[l])
      );
    end else begin : g_off
      assign lane_sum[l] = 32'd0;
    end
  end

  // Merge lane sums into the result register
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int p = 0; p < gr16_pkg::PAIRS; p++) begin
        sums[p] <= {lane_sum[2 * p + 1], lane_sum[2 * p]};
      end
    end
  end

  assign sums_pair_0 = sums[0];
  assign sums_pair_1 = sums[1];
  assign sums_pair_2 = sums[2];
  assign sums_pair_3 = sums[3];
  assign sums_pair_4 = sums[4];
  assign sums_pair_5 = sums[5];
  assign sums_pair_6 = sums[6];
  assign sums_pair_7 = sums[7];

endmodule

// File: design/gr16_checker.sv
// Port-level checker for the row accumulator, bound to the top level.
// Depends only on the top level's ports.
module gr16_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic last_step,
  input logic out_valid,
  input logic out_stall
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  // Stall the input after a transaction starts
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("input taken during work");

  // No result from a step that is not last
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_step |-> ##5 !$rose(out_valid))
    else $error("result from a non-final step");

  // A last step with a free result register gives a result
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_step && !out_valid |-> ##5 out_valid)
    else $error("missing result");

endmodule

bind gemm_row_dot16_accumulator gr16_checker u_gr16_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last_step (last_step),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

// File: dv/gemm_row_dot16_checker.sv
// Scoreboard for the sixteen-lane fp32 row accumulator: watches both channels,
// predicts the lane sums and compares each emitted transaction.
// Depends on gr16_pkg for the lane count and the weight format codes.
`timescale 1ns / 1ps

module gemm_row_dot16_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] activation,
  input  logic [63:0] weights_pair_0,
  input  logic [63:0] weights_pair_1,
  input  logic [63:0] weights_pair_2,
  input  logic [63:0] weights_pair_3,
  input  logic [63:0] weights_pair_4,
  input  logic [63:0] weights_pair_5,
  input  logic [63:0] weights_pair_6,
  input  logic [63:0] weights_pair_7,
  input  logic        last_step,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] sums_pair_0,
  input  logic [63:0] sums_pair_1,
  input  logic [63:0] sums_pair_2,
  input  logic [63:0] sums_pair_3,
  input  logic [63:0] sums_pair_4,
  input  logic [63:0] sums_pair_5,
  input  logic [63:0] sums_pair_6,
  input  logic [63:0] sums_pair_7,
  output int          errors,
  output int          pending
);

  localparam logic [31:0] POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] DEF_NAN  = 32'h7FC0_0000;

  logic [1:0]   fmt_q;
  logic [31:0]  lane_sum [gr16_pkg::LANES];
  logic [511:0] sums_expected [$];

  function automatic logic [63:0] shift_sticky(logic [63:0] x, int n);
    if (n == 0) return x;
    if (n >= 64) return {63'b0, x != 64'd0};
    return (x >> n) | {63'b0, (x & ((64'd1 << n) - 64'd1)) != 64'd0};
  endfunction

  // Round sig * 2^(e - 189) to fp32, nearest even
  function automatic logic [31:0] fp_round(logic [31:0] s, int e, logic [63:0] sig);
    logic [63:0] rem;
    logic [31:0] mant;
    logic [31:0] base;
    logic [31:0] bits;
    while (sig[63]) begin
      sig = shift_sticky(sig, 1);
      e++;
    end
    while (!sig[62]) begin
      sig = sig << 1;
      e--;
    end
    if (e >= 255) return s | POS_INF;
    if (e < 1) begin
      sig = shift_sticky(sig, 1 - e);
      base = 32'd0;
    end else begin
      base = 32'(e - 1) << 23;
    end
    mant = 32'(sig >> 39);
    rem = sig & ((64'd1 << 39) - 64'd1);
    if (rem > (64'd1 << 38) || (rem == (64'd1 << 38) && mant[0])) mant++;
    bits = base + mant;
    if (bits >= POS_INF) return s | POS_INF;
    return s | bits;
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic [31:0] s;
    int          ea, eb;
    logic [31:0] ma, mb;
    logic        za, zb;
    s = (a ^ b) & 32'h8000_0000;
    ea = a[30:23];
    eb = b[30:23];
    ma = {9'b0, a[22:0]};
    mb = {9'b0, b[22:0]};
    za = (ea == 0 && ma == 0);
    zb = (eb == 0 && mb == 0);
    if ((ea == 255 && ma != 0) || (eb == 255 && mb != 0)) return DEF_NAN;
    if (ea == 255 || eb == 255) return (za || zb) ? DEF_NAN : (s | POS_INF);
    if (za || zb) return s;
    if (ea != 0) ma[23] = 1'b1; else ea = 1;
    if (eb != 0) mb[23] = 1'b1; else eb = 1;
    return fp_round(s, ea + eb - 111, 64'(ma) * 64'(mb));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] sa, sb, tmp;
    int          ea, eb, ti;
    logic [31:0] ma, mb;
    logic [63:0] xa, xb, r;
    sa = a & 32'h8000_0000;
    sb = b & 32'h8000_0000;
    ea = a[30:23];
    eb = b[30:23];
    ma = {9'b0, a[22:0]};
    mb = {9'b0, b[22:0]};
    if ((ea == 255 && ma != 0) || (eb == 255 && mb != 0)) return DEF_NAN;
    if (ea == 255 && eb == 255) return (sa != sb) ? DEF_NAN : a;
    if (ea == 255) return a;
    if (eb == 255) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return a & b & 32'h8000_0000;
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    if (ea != 0) ma[23] = 1'b1; else ea = 1;
    if (eb != 0) mb[23] = 1'b1; else eb = 1;
    if (eb > ea || (eb == ea && mb > ma)) begin
      ti = ea; ea = eb; eb = ti;
      tmp = ma; ma = mb; mb = tmp;
      tmp = sa; sa = sb; sb = tmp;
    end
    xa = 64'(ma) << 39;
    xb = shift_sticky(64'(mb) << 39, ea - eb);
    if (sa == sb) begin
      r = xa + xb;
    end else begin
      if (xa == xb) return 32'd0;
      r = xa - xb;
    end
    return fp_round(sa, ea, r);
  endfunction

  // Exact fp16 to fp32, normalising subnormals
  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [31:0] s;
    logic [31:0] m;
    int          ex;
    s = {h[15], 31'b0};
    m = {22'b0, h[9:0]};
    if (h[14:10] == 5'd31) return s | POS_INF | (m << 13);
    if (h[14:10] == 5'd0) begin
      if (m == 0) return s;
      ex = 1;
      while (!m[10]) begin
        m = m << 1;
        ex--;
      end
      return s | (32'(ex + 112) << 23) | ((m & 32'h3FF) << 13);
    end
    return s | (32'(h[14:10] + 112) << 23) | (m << 13);
  endfunction

  function automatic logic [31:0] decode_weight(logic [1:0] fmt, logic [31:0] slot);
    if (fmt == gr16_pkg::FMT_F16) return half_to_single(slot[15:0]);
    if (fmt == gr16_pkg::FMT_BF16) return {slot[15:0], 16'b0};
    return slot;
  endfunction

  function automatic bit is_nan(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 0;
  endfunction

  task automatic report_mismatch(int lane, logic [31:0] want, logic [31:0] got);
    $display("%0t: lane %0d sum mismatch: expected %h, got %h", $realtime, lane, want, got);
    errors++;
  endtask

  logic [63:0] w_pairs [8];
  logic [63:0] s_pairs [8];
  assign w_pairs = '{weights_pair_0, weights_pair_1, weights_pair_2, weights_pair_3,
                     weights_pair_4, weights_pair_5, weights_pair_6, weights_pair_7};
  assign s_pairs = '{sums_pair_0, sums_pair_1, sums_pair_2, sums_pair_3,
                     sums_pair_4, sums_pair_5, sums_pair_6, sums_pair_7};

  initial errors = 0;
  initial pending = 0;

  // Track the format, accumulate each accepted step, check each emitted sum set
  always @(posedge clk) begin
    logic [511:0] want;
    logic [31:0]  got, slot;
    if (rst) begin
      fmt_q = gr16_pkg::FMT_F32;
      foreach (lane_sum[l]) lane_sum[l] = 32'd0;
    end else begin
      if (in_valid && !in_stall) begin
        want = '0;
        for (int l = 0; l < gr16_pkg::LANES; l++) begin
          slot = l[0] ? w_pairs[l >> 1][63:32] : w_pairs[l >> 1][31:0];
          lane_sum[l] = fp_add(lane_sum[l], fp_mul(activation, decode_weight(fmt_q, slot)));
          want[l*32 +: 32] = lane_sum[l];
        end
        if (last_step) begin
          sums_expected.push_back(want);
          foreach (lane_sum[l]) lane_sum[l] = 32'd0;
        end
      end
      if (out_valid && !out_stall) begin
        if (sums_expected.size() == 0) begin
          $display("%0t: sum transaction with nothing outstanding", $realtime);
          errors++;
        end else begin
          want = sums_expected.pop_front();
          for (int l = 0; l < 16; l++) begin
            got = l[0] ? s_pairs[l >> 1][63:32] : s_pairs[l >> 1][31:0];
            if (is_nan(want[l*32 +: 32]) ? !is_nan(got) : got !== want[l*32 +: 32])
              report_mismatch(l, want[l*32 +: 32], got);
          end
        end
      end
      if (cfg_we) fmt_q = cfg_wdata;
    end
    pending = sums_expected.size();
  end

endmodule

// File: dv/gemm_row_dot16_accumulator_tb.sv
// Stimulus and verdict for the sixteen-lane fp32 row accumulator.
// Depends on gr16_pkg, the design and gemm_row_dot16_checker.
`timescale 1ns / 1ps

module gemm_row_dot16_accumulator_tb;

  // Format code with no encoding of its own; decodes as fp32
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] activation;
  logic [63:0] wp [8];
  logic        last_step;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] sp [8];
  int          errors;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;
  logic [1:0]  cur_fmt;

  gemm_row_dot16_accumulator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .activation(activation),
    .weights_pair_0(wp[0]), .weights_pair_1(wp[1]), .weights_pair_2(wp[2]),
    .weights_pair_3(wp[3]), .weights_pair_4(wp[4]), .weights_pair_5(wp[5]),
    .weights_pair_6(wp[6]), .weights_pair_7(wp[7]), .last_step(last_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .sums_pair_0(sp[0]), .sums_pair_1(sp[1]), .sums_pair_2(sp[2]), .sums_pair_3(sp[3]),
    .sums_pair_4(sp[4]), .sums_pair_5(sp[5]), .sums_pair_6(sp[6]), .sums_pair_7(sp[7])
  );

  gemm_row_dot16_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .activation(activation),
    .weights_pair_0(wp[0]), .weights_pair_1(wp[1]), .weights_pair_2(wp[2]),
    .weights_pair_3(wp[3]), .weights_pair_4(wp[4]), .weights_pair_5(wp[5]),
    .weights_pair_6(wp[6]), .weights_pair_7(wp[7]), .last_step(last_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .sums_pair_0(sp[0]), .sums_pair_1(sp[1]), .sums_pair_2(sp[2]), .sums_pair_3(sp[3]),
    .sums_pair_4(sp[4]), .sums_pair_5(sp[5]), .sums_pair_6(sp[6]), .sums_pair_7(sp[7]),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Random receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
  end

  // Abort if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one step and hold it until taken; valid stays up for the next step
  task automatic drive_step(logic [31:0] act, logic [31:0] lanes [16], logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    activation <= act;
    for (int p = 0; p < 8; p++) wp[p] <= {lanes[2*p+1], lanes[2*p]};
    last_step <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, drain outstanding sums, let the pipeline settle, then set the format
  task automatic set_format(logic [1:0] fmt);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= fmt;
    cur_fmt = fmt;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly moderate magnitudes, with specials and raw patterns mixed in
  function automatic logic [31:0] rand_value(logic [1:0] fmt);
    logic [31:0] raw;
    int          kind;
    raw = $urandom;
    kind = $urandom_range(9);
    if (fmt == gr16_pkg::FMT_F16) begin
      case (kind)
        0: return {raw[31:16], raw[15], 5'd0, raw[9:0]};
        1: return {raw[31:16], raw[15], 5'd31, (raw[0] ? 10'd0 : raw[9:0])};
        2: return raw;
        default: return {raw[31:16], raw[15], 5'($urandom_range(20, 10)), raw[9:0]};
      endcase
    end
    if (fmt == gr16_pkg::FMT_BF16) begin
      case (kind)
        0: return {raw[31:16], raw[15], 8'd0, raw[6:0]};
        1: return {raw[31:16], raw[15], 8'hFF, (raw[0] ? 7'd0 : raw[6:0])};
        2: return raw;
        default: return {raw[31:16], raw[15], 8'($urandom_range(134, 120)), raw[6:0]};
      endcase
    end
    case (kind)
      0: return {raw[31], 8'd0, raw[22:0]};
      1: return {raw[31], 8'hFF, (raw[0] ? 23'd0 : raw[22:0])};
      2: return raw;
      3: return {raw[31], 31'd0};
      default: return {raw[31], 8'($urandom_range(134, 120)), raw[22:0]};
    endcase
  endfunction

  task automatic random_runs(int steps);
    logic [31:0] lanes [16];
    logic [31:0] act;
    int          run_len;
    int          done;
    done = 0;
    while (done < steps) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
      for (int k = 0; k < run_len; k++) begin
        act = rand_value(gr16_pkg::FMT_F32);
        foreach (lanes[l]) lanes[l] = rand_value(cur_fmt);
        drive_step(act, lanes, k == run_len - 1);
      end
      done += run_len;
    end
  endtask

  task automatic fill_lanes(output logic [31:0] lanes [16], input logic [31:0] v);
    foreach (lanes[l]) lanes[l] = v;
  endtask

  initial begin
    logic [31:0] lanes [16];
    logic [1:0]  fmt_seq [12];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = gr16_pkg::FMT_F32;
    in_valid = 1'b0;
    out_stall = 1'b0;
    activation = '0;
    last_step = 1'b0;
    foreach (wp[p]) wp[p] = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_fmt = gr16_pkg::FMT_F32;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fp32 extremes: zeros, infinities, NaN, inf times zero, cancellation
    fill_lanes(lanes, 32'h0000_0000);
    lanes[1] = 32'h8000_0000; lanes[2] = 32'h7F80_0000; lanes[3] = 32'hFF80_0000;
    lanes[4] = 32'h7FFF_FFFF; lanes[5] = 32'h7F7F_FFFF; lanes[6] = 32'h0000_0001;
    lanes[7] = 32'hFFFF_FFFF; lanes[8] = 32'h3F80_0000; lanes[9] = 32'h807F_FFFF;
    drive_step(32'h3F80_0000, lanes, 1'b0);
    drive_step(32'hBF80_0000, lanes, 1'b1);
    drive_step(32'h7F80_0000, lanes, 1'b1);
    drive_step(32'h7F7F_FFFF, lanes, 1'b0);
    drive_step(32'h7F7F_FFFF, lanes, 1'b1);
    drive_step(32'h0000_0001, lanes, 1'b1);
    drive_step(32'h8000_0000, lanes, 1'b0);
    drive_step(32'h8000_0000, lanes, 1'b1);
    drive_step(32'hFFC0_0001, lanes, 1'b1);
    fill_lanes(lanes, 32'hFFFF_FFFF);
    drive_step(32'h7F80_0000, lanes, 1'b1);

    // fp16: subnormals, infinities, NaN, ignored upper slot bits
    set_format(gr16_pkg::FMT_F16);
    fill_lanes(lanes, 32'hFFFF_0001);
    lanes[1] = 32'h0000_03FF; lanes[2] = 32'hA5A5_7C00; lanes[3] = 32'h0000_FC00;
    lanes[4] = 32'h0000_7E01; lanes[5] = 32'h0000_7BFF; lanes[6] = 32'h0000_8000;
    lanes[7] = 32'h1234_0400; lanes[8] = 32'h0000_3C00; lanes[9] = 32'h0000_8001;
    drive_step(32'h3F80_0000, lanes, 1'b0);
    drive_step(32'hC000_0000, lanes, 1'b1);
    drive_step(32'h0000_0000, lanes, 1'b1);

    // bf16 and the unused format code
    set_format(gr16_pkg::FMT_BF16);
    lanes[0] = 32'hFFFF_7F80; lanes[1] = 32'h0000_0001; lanes[2] = 32'h0000_7F7F;
    drive_step(32'h7F7F_FFFF, lanes, 1'b0);
    drive_step(32'h3F80_0000, lanes, 1'b1);
    set_format(FMT_UNUSED);
    drive_step(32'h4000_0000, lanes, 1'b1);

    // Random runs across formats and flow-control regimes
    fmt_seq = '{gr16_pkg::FMT_F32, gr16_pkg::FMT_F16, gr16_pkg::FMT_BF16, FMT_UNUSED,
                gr16_pkg::FMT_BF16, gr16_pkg::FMT_F16, gr16_pkg::FMT_F32, gr16_pkg::FMT_F16,
                FMT_UNUSED, gr16_pkg::FMT_BF16, gr16_pkg::FMT_F32, gr16_pkg::FMT_F16};
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 15 : (ph < 8) ? 70 : 0;
      recv_stall_pct = (ph < 4) ? 70 : (ph < 8) ? 15 : 0;
      set_format(fmt_seq[ph]);
      random_runs(70);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
